// ----- hw/rtl/aslex_pkg.sv -----
// Package: lexer state codes, token kinds, queue types and the transition function.
`timescale 1ns / 1ps
`default_nettype none

package aslex_pkg;

    // Automaton states
    localparam logic [5:0] S_START   = 6'd0;
    localparam logic [5:0] S_CMT     = 6'd1;
    localparam logic [5:0] S_CMT_NL  = 6'd2;
    localparam logic [5:0] S_FLG0    = 6'd3;
    localparam logic [5:0] S_FLG     = 6'd4;
    localparam logic [5:0] S_REG0    = 6'd5;
    localparam logic [5:0] S_REG     = 6'd6;
    localparam logic [5:0] S_ZERO    = 6'd7;
    localparam logic [5:0] S_MINUS   = 6'd8;
    localparam logic [5:0] S_HEX0    = 6'd9;
    localparam logic [5:0] S_HEX     = 6'd10;
    localparam logic [5:0] S_DEC     = 6'd11;
    localparam logic [5:0] S_LBL     = 6'd12;
    localparam logic [5:0] S_STR     = 6'd13;
    localparam logic [5:0] S_ESC     = 6'd14;
    localparam logic [5:0] S_STR_END = 6'd15;
    localparam logic [5:0] S_COLON   = 6'd16;
    localparam logic [5:0] S_LCUR    = 6'd17;
    localparam logic [5:0] S_RCUR    = 6'd18;
    localparam logic [5:0] S_U       = 6'd19;
    localparam logic [5:0] S_UL      = 6'd20;
    localparam logic [5:0] S_ULA     = 6'd21;
    localparam logic [5:0] S_DOT     = 6'd22;
    localparam logic [5:0] S_DB      = 6'd23;
    localparam logic [5:0] S_DBS     = 6'd24;
    localparam logic [5:0] S_DBSS    = 6'd25;
    localparam logic [5:0] S_DD      = 6'd26;
    localparam logic [5:0] S_DDA     = 6'd27;
    localparam logic [5:0] S_DDAT    = 6'd28;
    localparam logic [5:0] S_DDATA   = 6'd29;
    localparam logic [5:0] S_A       = 6'd30;
    localparam logic [5:0] S_AN      = 6'd31;
    localparam logic [5:0] S_AD      = 6'd32;
    localparam logic [5:0] S_AND     = 6'd33;
    localparam logic [5:0] S_ADD     = 6'd34;
    localparam logic [5:0] S_O       = 6'd35;
    localparam logic [5:0] S_OR      = 6'd36;
    localparam logic [5:0] S_ORR     = 6'd37;
    localparam logic [5:0] S_S       = 6'd38;
    localparam logic [5:0] S_SH      = 6'd39;
    localparam logic [5:0] S_SU      = 6'd40;
    localparam logic [5:0] S_SHL     = 6'd41;
    localparam logic [5:0] S_SHR     = 6'd42;
    localparam logic [5:0] S_SUB     = 6'd43;
    localparam logic [5:0] S_X       = 6'd44;
    localparam logic [5:0] S_XO      = 6'd45;
    localparam logic [5:0] S_XOR     = 6'd46;

    // Token kinds
    localparam logic [4:0] K_ERROR   = 5'd0;
    localparam logic [4:0] K_EOF     = 5'd1;
    localparam logic [4:0] K_COMMENT = 5'd2;
    localparam logic [4:0] K_FLAGS   = 5'd3;
    localparam logic [4:0] K_REG     = 5'd4;
    localparam logic [4:0] K_IMM     = 5'd5;
    localparam logic [4:0] K_LABEL   = 5'd6;
    localparam logic [4:0] K_STRING  = 5'd7;
    localparam logic [4:0] K_COLON   = 5'd8;
    localparam logic [4:0] K_LCURLY  = 5'd9;
    localparam logic [4:0] K_RCURLY  = 5'd10;
    localparam logic [4:0] K_LA      = 5'd11;
    localparam logic [4:0] K_BSS     = 5'd12;
    localparam logic [4:0] K_DATA    = 5'd13;
    localparam logic [4:0] K_AND     = 5'd14;
    localparam logic [4:0] K_ADD     = 5'd15;
    localparam logic [4:0] K_ORR     = 5'd16;
    localparam logic [4:0] K_SHL     = 5'd17;
    localparam logic [4:0] K_SHR     = 5'd18;
    localparam logic [4:0] K_SUB     = 5'd19;
    localparam logic [4:0] K_XOR     = 5'd20;
    localparam logic [4:0] K_MAX     = K_XOR;

    localparam logic [7:0] C_EOB = 8'hFF;

    localparam int QDEPTH = 4;   // power of two

    // One transition outcome: error, token (val = kind) or next state (val)
    typedef struct packed {
        logic       err;
        logic       tok;
        logic [5:0] val;
    } t_step;

    // One queue entry: results caused by one item
    typedef struct packed {
        logic       two;
        logic [4:0] kind0;
        logic [4:0] kind1;
    } t_run;

    function automatic logic in_rng(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic logic is_dig(logic [7:0] b);
        return in_rng(b, "0", "9");
    endfunction

    function automatic logic is_lbl(logic [7:0] b);
        return in_rng(b, "a", "z") || in_rng(b, "A", "Z") || is_dig(b) || (b == "_");
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return in_rng(b, "a", "f") || in_rng(b, "A", "F") || is_dig(b);
    endfunction

    function automatic logic is_ws(logic [7:0] b);
        return (b == " ") || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic t_step go(logic [5:0] s);
        t_step r;
        r.err = 1'b0;
        r.tok = 1'b0;
        r.val = s;
        return r;
    endfunction

    function automatic t_step tok(logic [4:0] k);
        t_step r;
        r.err = 1'b0;
        r.tok = 1'b1;
        r.val = {1'b0, k};
        return r;
    endfunction

    function automatic t_step err();
        t_step r;
        r.err = 1'b1;
        r.tok = 1'b0;
        r.val = S_START;
        return r;
    endfunction

    function automatic t_step kw(logic [7:0] b, logic [7:0] c, logic [5:0] nx);
        if (b == c) return go(nx);
        return is_lbl(b) ? go(S_LBL) : err();
    endfunction

    function automatic t_step kw_end(logic [7:0] b, logic [4:0] k);
        return is_lbl(b) ? go(S_LBL) : tok(k);
    endfunction

    function automatic t_step next_of(logic [5:0] st, logic [7:0] b);
        t_step r;
        r = err();
        unique case (st)
            S_START: begin
                priority if (is_ws(b))            r = go(S_START);
                else if (b == C_EOB)              r = tok(K_EOF);
                else if (b == ";")                r = go(S_CMT);
                else if (b == "%")                r = go(S_FLG0);
                else if (b == "$")                r = go(S_REG0);
                else if (b == "0")                r = go(S_ZERO);
                else if (b == "-")                r = go(S_MINUS);
                else if (in_rng(b, "1", "9"))     r = go(S_DEC);
                else if (b == 8'h22)              r = go(S_STR);
                else if (b == ":")                r = go(S_COLON);
                else if (b == "{")                r = go(S_LCUR);
                else if (b == "}")                r = go(S_RCUR);
                else if (b == "_")                r = go(S_U);
                else if (b == ".")                r = go(S_DOT);
                else if (b == "A")                r = go(S_A);
                else if (b == "O")                r = go(S_O);
                else if (b == "S")                r = go(S_S);
                else if (b == "X")                r = go(S_X);
                else if (is_lbl(b))               r = go(S_LBL);
                else                              r = err();
            end
            S_CMT: begin
                priority if (b == 8'h0A) r = go(S_CMT_NL);
                else if (b == C_EOB)     r = tok(K_COMMENT);
                else                     r = go(S_CMT);
            end
            S_CMT_NL:  r = tok(K_COMMENT);
            S_FLG0:    r = in_rng(b, "a", "z") ? go(S_FLG) : err();
            S_FLG:     r = in_rng(b, "a", "z") ? go(S_FLG) : tok(K_FLAGS);
            S_REG0:    r = is_dig(b) ? go(S_REG) : err();
            S_REG:     r = is_dig(b) ? go(S_REG) : tok(K_REG);
            S_ZERO: begin
                priority if (b == "x") r = go(S_HEX0);
                else if (is_dig(b))    r = go(S_DEC);
                else                   r = tok(K_IMM);
            end
            S_MINUS:   r = is_dig(b) ? go(S_DEC) : err();
            S_HEX0:    r = is_hex(b) ? go(S_HEX) : err();
            S_HEX:     r = is_hex(b) ? go(S_HEX) : tok(K_IMM);
            S_DEC:     r = is_dig(b) ? go(S_DEC) : tok(K_IMM);
            S_LBL:     r = is_lbl(b) ? go(S_LBL) : tok(K_LABEL);
            S_STR: begin
                priority if (b == 8'h5C)            r = go(S_ESC);
                else if (b == 8'h22)                r = go(S_STR_END);
                else if (b == 8'h0A || b == C_EOB)  r = err();
                else                                r = go(S_STR);
            end
            S_ESC:     r = (b == 8'h0A || b == C_EOB) ? err() : go(S_STR);
            S_STR_END: r = tok(K_STRING);
            S_COLON:   r = tok(K_COLON);
            S_LCUR:    r = tok(K_LCURLY);
            S_RCUR:    r = tok(K_RCURLY);
            S_U:       r = kw(b, "l", S_UL);
            S_UL:      r = kw(b, "a", S_ULA);
            S_ULA:     r = kw_end(b, K_LA);
            S_DOT: begin
                priority if (b == "b") r = go(S_DB);
                else if (b == "d")     r = go(S_DD);
                else                   r = err();
            end
            S_DB:      r = (b == "s") ? go(S_DBS) : err();
            S_DBS:     r = (b == "s") ? go(S_DBSS) : err();
            S_DBSS:    r = tok(K_BSS);
            S_DD:      r = (b == "a") ? go(S_DDA) : err();
            S_DDA:     r = (b == "t") ? go(S_DDAT) : err();
            S_DDAT:    r = (b == "a") ? go(S_DDATA) : err();
            S_DDATA:   r = tok(K_DATA);
            S_A:       r = (b == "N") ? go(S_AN) : kw(b, "D", S_AD);
            S_AN:      r = kw(b, "D", S_AND);
            S_AD:      r = kw(b, "D", S_ADD);
            S_AND:     r = kw_end(b, K_AND);
            S_ADD:     r = kw_end(b, K_ADD);
            S_O:       r = kw(b, "R", S_OR);
            S_OR:      r = kw(b, "R", S_ORR);
            S_ORR:     r = kw_end(b, K_ORR);
            S_S:       r = (b == "H") ? go(S_SH) : kw(b, "U", S_SU);
            S_SH:      r = (b == "L") ? go(S_SHL) : kw(b, "R", S_SHR);
            S_SU:      r = kw(b, "B", S_SUB);
            S_SHL:     r = kw_end(b, K_SHL);
            S_SHR:     r = kw_end(b, K_SHR);
            S_SUB:     r = kw_end(b, K_SUB);
            S_X:       r = kw(b, "O", S_XO);
            S_XO:      r = kw(b, "R", S_XOR);
            S_XOR:     r = kw_end(b, K_XOR);
            default:   r = err();   // unreachable codes
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/aslex_front.sv -----
// Front end: lexer state register and per-byte classification into queue entries.
`timescale 1ns / 1ps
`default_nettype none

module aslex_front
    import aslex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char_byte,
    output logic            o_q_push,
    output t_run            o_q_run
);

    logic [5:0] r_state;
    logic [5:0] n_state;
    t_step      w_first;
    t_step      w_rerun;

    assign w_first = next_of(r_state, i_char_byte);
    assign w_rerun = next_of(S_START, i_char_byte);

    always_comb begin
        n_state         = r_state;
        o_q_push        = 1'b0;
        o_q_run.two     = 1'b0;
        o_q_run.kind0   = K_ERROR;
        o_q_run.kind1   = K_ERROR;
        if (i_accept) begin
            priority if (w_first.err) begin
                o_q_push = 1'b1;
                n_state  = S_START;
            end else if (!w_first.tok) begin
                n_state = w_first.val;
            end else begin
                // token closed; re-run the byte from start unless already there
                o_q_push      = 1'b1;
                o_q_run.kind0 = w_first.val[4:0];
                n_state       = S_START;
                if (r_state != S_START) begin
                    if (!w_rerun.err && !w_rerun.tok) begin
                        n_state = w_rerun.val;
                    end else begin
                        o_q_run.two   = 1'b1;
                        o_q_run.kind1 = w_rerun.err ? K_ERROR : w_rerun.val[4:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/aslex_back.sv -----
// Back end: entry queue and unpacking of one- and two-result entries.
`timescale 1ns / 1ps
`default_nettype none

module aslex_back
    import aslex_pkg::*;
#(
    parameter int DEPTH = QDEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_push,
    input  wire t_run       i_q_run,
    output logic            o_q_full,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [4:0]      o_token_kind,
    output logic            o_last_of_run
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_run            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_sub;
    logic            n_sub;
    t_run            w_head;
    logic            w_take;
    logic            w_deq;

    assign w_head   = r_mem[r_rd];
    assign o_empty  = (r_count == '0);
    assign o_q_full = (r_count == CW'(DEPTH));

    assign o_token_kind  = r_sub ? w_head.kind1 : w_head.kind0;
    assign o_last_of_run = r_sub || !w_head.two;

    assign w_take = i_pop && !o_empty;
    assign w_deq  = w_take && o_last_of_run;

    always_comb begin
        n_sub = r_sub;
        if (w_take) begin
            n_sub = !o_last_of_run;
        end
        n_count = r_count + CW'(i_q_push) - CW'(w_deq);
    end

    always_ff @(posedge i_clk) begin
        if (i_q_push) begin
            r_mem[r_wr] <= i_q_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (i_q_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_deq) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= n_count;
            r_sub   <= n_sub;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/assembly_token_lexer.sv -----
// Top level of the assembly token lexer: front end, entry queue and result unpacker.
//
// Usage:
//   Input channel is queue-like: drive i_char_byte and raise push; the byte
//   is taken at a clock edge where push is high and full is low. 0xFF is end
//   of input. Result channel is queue-like too: while empty is low,
//   o_token_kind and o_last_of_run show the oldest result; pop takes it.
//   Each byte yields zero, one or two results; o_last_of_run marks the final
//   one of a byte. Errors come out as kind 0 and the lexer restarts.
// Timing: a byte's entry is written into the queue at the edge that accepts it.
// Throughput: one byte per cycle while full is low. A byte with results occupies one queue
//   entry; a two-result entry needs two pops, so output drain sets the
//   sustained rate when many bytes close tokens.
// Stall: the queue holds DEPTH entries. When the receiver stops popping the
//   queue fills and full rises; bytes with no result still need a free slot.
// Reset: synchronous, active low; lexer returns to its start state and the
//   queue is emptied. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module assembly_token_lexer
    import aslex_pkg::*;
#(
    parameter int DEPTH = QDEPTH    // queue entries, power of two
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [4:0]      o_token_kind,
    output logic            o_last_of_run
);

    logic   w_accept;
    logic   w_q_push;
    t_run   w_q_run;

    // full is registered queue occupancy, so accept never depends on pop
    assign w_accept = push && !full;

    aslex_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_char_byte (i_char_byte),
        .o_q_push    (w_q_push),
        .o_q_run     (w_q_run)
    );

    aslex_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_push      (w_q_push),
        .i_q_run       (w_q_run),
        .o_q_full      (full),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_token_kind  (o_token_kind),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/aslex_checker.sv -----
// Port-level checker for the assembly token lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module aslex_checker
    import aslex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic [4:0] o_token_kind,
    input  wire logic       o_last_of_run
);

    // reset leaves both sides open and nothing to deliver
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

    // results only appear after an accepted byte
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result without accepted item");

    // first of a two-result run is always followed by its partner
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_run) |=> !empty)
        else $error("second result of a run missing");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_token_kind <= K_MAX))
        else $error("token kind out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_token_kind) && $stable(o_last_of_run)))
        else $error("stalled result changed");

endmodule

bind assembly_token_lexer aslex_checker u_aslex_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_token_kind  (o_token_kind),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire

// ----- verif/lexer_checker.sv -----
// Checker for the assembly token lexer: predicts the token results of each byte and compares them.
`timescale 1ns / 1ps

module lexer_checker
    import aslex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic       i_full,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_empty,
    input  wire logic       i_pop,
    input  wire logic [4:0] i_token_kind,
    input  wire logic       i_last_of_run,
    output int              o_mismatches,
    output int              o_pending
);

    // Outcome of one automaton step: error, closed token, or a move to nxt.
    typedef struct packed {
        logic       fail;
        logic       emit;
        logic [4:0] kind;
        logic [5:0] nxt;
    } t_lex_move;

    typedef struct packed {
        logic [4:0] kind;
        logic       last;
    } t_token;

    t_token     token_q[$];
    logic [5:0] lex_state = S_START;
    int         mismatches = 0;

    function automatic logic digit_c(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic lower_c(logic [7:0] c);
        return (c >= "a") && (c <= "z");
    endfunction

    function automatic logic word_c(logic [7:0] c);
        return lower_c(c) || ((c >= "A") && (c <= "Z")) || digit_c(c) || (c == "_");
    endfunction

    function automatic logic hexd_c(logic [7:0] c);
        return digit_c(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic blank_c(logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic t_lex_move move_to(logic [5:0] s);
        return {1'b0, 1'b0, K_ERROR, s};
    endfunction

    function automatic t_lex_move close_as(logic [4:0] k);
        return {1'b0, 1'b1, k, S_START};
    endfunction

    function automatic t_lex_move reject();
        return {1'b1, 1'b0, K_ERROR, S_START};
    endfunction

    // keyword letter: exact letter advances, other word chars fall into a label
    function automatic t_lex_move kw_char(logic [7:0] c, logic [7:0] want, logic [5:0] nx);
        if (c == want)
            return move_to(nx);
        return word_c(c) ? move_to(S_LBL) : reject();
    endfunction

    function automatic t_lex_move kw_close(logic [7:0] c, logic [4:0] k);
        return word_c(c) ? move_to(S_LBL) : close_as(k);
    endfunction

    function automatic t_lex_move lex_transition(logic [5:0] st, logic [7:0] c);
        case (st)
            S_START: begin
                if (blank_c(c))               return move_to(S_START);
                if (c == C_EOB)               return close_as(K_EOF);
                if (c == ";")                 return move_to(S_CMT);
                if (c == "%")                 return move_to(S_FLG0);
                if (c == "$")                 return move_to(S_REG0);
                if (c == "0")                 return move_to(S_ZERO);
                if (c == "-")                 return move_to(S_MINUS);
                if (digit_c(c))               return move_to(S_DEC);
                if (c == 8'h22)               return move_to(S_STR);
                if (c == ":")                 return move_to(S_COLON);
                if (c == "{")                 return move_to(S_LCUR);
                if (c == "}")                 return move_to(S_RCUR);
                if (c == "_")                 return move_to(S_U);
                if (c == ".")                 return move_to(S_DOT);
                if (c == "A")                 return move_to(S_A);
                if (c == "O")                 return move_to(S_O);
                if (c == "S")                 return move_to(S_S);
                if (c == "X")                 return move_to(S_X);
                if (word_c(c))                return move_to(S_LBL);
                return reject();
            end
            S_CMT: begin
                if (c == 8'h0A)               return move_to(S_CMT_NL);
                if (c == C_EOB)               return close_as(K_COMMENT);
                return move_to(S_CMT);
            end
            S_CMT_NL:  return close_as(K_COMMENT);
            S_FLG0:    return lower_c(c) ? move_to(S_FLG) : reject();
            S_FLG:     return lower_c(c) ? move_to(S_FLG) : close_as(K_FLAGS);
            S_REG0:    return digit_c(c) ? move_to(S_REG) : reject();
            S_REG:     return digit_c(c) ? move_to(S_REG) : close_as(K_REG);
            S_ZERO: begin
                if (c == "x")                 return move_to(S_HEX0);
                return digit_c(c) ? move_to(S_DEC) : close_as(K_IMM);
            end
            S_MINUS:   return digit_c(c) ? move_to(S_DEC) : reject();
            S_HEX0:    return hexd_c(c) ? move_to(S_HEX) : reject();
            S_HEX:     return hexd_c(c) ? move_to(S_HEX) : close_as(K_IMM);
            S_DEC:     return digit_c(c) ? move_to(S_DEC) : close_as(K_IMM);
            S_LBL:     return word_c(c) ? move_to(S_LBL) : close_as(K_LABEL);
            S_STR: begin
                if (c == 8'h5C)               return move_to(S_ESC);
                if (c == 8'h22)               return move_to(S_STR_END);
                if (c == 8'h0A || c == C_EOB) return reject();
                return move_to(S_STR);
            end
            S_ESC:     return (c == 8'h0A || c == C_EOB) ? reject() : move_to(S_STR);
            S_STR_END: return close_as(K_STRING);
            S_COLON:   return close_as(K_COLON);
            S_LCUR:    return close_as(K_LCURLY);
            S_RCUR:    return close_as(K_RCURLY);
            S_U:       return kw_char(c, "l", S_UL);
            S_UL:      return kw_char(c, "a", S_ULA);
            S_ULA:     return kw_close(c, K_LA);
            S_DOT: begin
                if (c == "b")                 return move_to(S_DB);
                if (c == "d")                 return move_to(S_DD);
                return reject();
            end
            S_DB:      return (c == "s") ? move_to(S_DBS) : reject();
            S_DBS:     return (c == "s") ? move_to(S_DBSS) : reject();
            S_DBSS:    return close_as(K_BSS);
            S_DD:      return (c == "a") ? move_to(S_DDA) : reject();
            S_DDA:     return (c == "t") ? move_to(S_DDAT) : reject();
            S_DDAT:    return (c == "a") ? move_to(S_DDATA) : reject();
            S_DDATA:   return close_as(K_DATA);
            S_A:       return (c == "N") ? move_to(S_AN) : kw_char(c, "D", S_AD);
            S_AN:      return kw_char(c, "D", S_AND);
            S_AD:      return kw_char(c, "D", S_ADD);
            S_AND:     return kw_close(c, K_AND);
            S_ADD:     return kw_close(c, K_ADD);
            S_O:       return kw_char(c, "R", S_OR);
            S_OR:      return kw_char(c, "R", S_ORR);
            S_ORR:     return kw_close(c, K_ORR);
            S_S:       return (c == "H") ? move_to(S_SH) : kw_char(c, "U", S_SU);
            S_SH:      return (c == "L") ? move_to(S_SHL) : kw_char(c, "R", S_SHR);
            S_SU:      return kw_char(c, "B", S_SUB);
            S_SHL:     return kw_close(c, K_SHL);
            S_SHR:     return kw_close(c, K_SHR);
            S_SUB:     return kw_close(c, K_SUB);
            S_X:       return kw_char(c, "O", S_XO);
            S_XO:      return kw_char(c, "R", S_XOR);
            S_XOR:     return kw_close(c, K_XOR);
            default:   return reject();
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] lexer mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_token(input logic [4:0] kind, input logic last);
        t_token t;
        t.kind = kind;
        t.last = last;
        token_q.push_back(t);
    endtask

    always @(posedge i_clk) begin : watch
        t_lex_move  step1;
        t_lex_move  step2;
        logic [5:0] st;
        t_token     want;

        if (!i_rst_n) begin
            lex_state = S_START;
            token_q.delete();
        end else begin
            // byte accepted: run the automaton, re-run a foreign closing byte
            if (i_push && !i_full) begin
                st = lex_state;
                step1 = lex_transition(st, i_char_byte);
                if (step1.fail) begin
                    queue_token(K_ERROR, 1'b1);
                    lex_state = S_START;
                end else if (!step1.emit) begin
                    lex_state = step1.nxt;
                end else if (st == S_START) begin
                    queue_token(step1.kind, 1'b1);
                    lex_state = S_START;
                end else begin
                    step2 = lex_transition(S_START, i_char_byte);
                    if (!step2.fail && !step2.emit) begin
                        queue_token(step1.kind, 1'b1);
                        lex_state = step2.nxt;
                    end else begin
                        queue_token(step1.kind, 1'b0);
                        queue_token(step2.fail ? K_ERROR : step2.kind, 1'b1);
                        lex_state = S_START;
                    end
                end
            end

            // result accepted: compare with the oldest prediction
            if (i_pop && !i_empty) begin
                if (token_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d last %0b",
                                              i_token_kind, i_last_of_run));
                end else begin
                    want = token_q.pop_front();
                    if (i_token_kind !== want.kind)
                        report_mismatch($sformatf("token_kind %0d, predicted %0d",
                                                  i_token_kind, want.kind));
                    if (i_last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %0b, predicted %0b",
                                                  i_last_of_run, want.last));
                end
            end
        end
        o_pending    <= token_q.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- verif/tb_assembly_token_lexer.sv -----
// Testbench top for the assembly token lexer: byte stimulus, result draining and verdict.
`timescale 1ns / 1ps

module tb_assembly_token_lexer;
    import aslex_pkg::*;

    // Worst case is roughly 2 results per byte under the sparsest pop pattern plus
    // sender gaps; ~1.9k bytes stay well within this limit.
    localparam int CYCLE_LIMIT = 600000;
    // source bytes to generate, blanks included
    localparam int WORD_TARGET = 1850;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] char_byte = 8'h00;
    logic       full;
    logic       empty;
    logic [4:0] token_kind;
    logic       last_of_run;

    int mismatches;
    int pending;
    int cycles = 0;
    int words = 0;

    // source text, in order of feeding
    logic [7:0] src_bytes[$];

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    assembly_token_lexer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .push          (push),
        .full          (full),
        .i_char_byte   (char_byte),
        .empty         (empty),
        .pop           (pop),
        .o_token_kind  (token_kind),
        .o_last_of_run (last_of_run)
    );

    lexer_checker lex_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_char_byte   (char_byte),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_token_kind  (token_kind),
        .i_last_of_run (last_of_run),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: a 16-bit pop pattern rotating each cycle, re-picked at random from
    // four kinds. Patterns always hold at least one pop so the queue drains.
    logic [15:0] stall_pat = 16'hFFFF;

    always @(negedge clk) begin
        if (cycles % 64 == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pat = 16'hFFFF;                      // no stalls
                1:       stall_pat = 16'($urandom_range(1, 16'hFFFF));   // random mix
                2:       stall_pat = 16'h0001 << $urandom_range(0, 15);  // heavy backpressure
                default: stall_pat = 16'h5555;
            endcase
        end
        pop <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    task automatic add_byte(input logic [7:0] c);
        src_bytes.push_back(c);
        words++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range("a", "z"));
            1:       return 8'($urandom_range("A", "Z"));
            2:       return 8'($urandom_range("0", "9"));
            default: return "_";
        endcase
    endfunction

    // One random token, mostly well formed, followed by a random separator.
    // An empty separator makes the next token close this one directly, which
    // exercises the re-run of the closing byte.
    task automatic emit_token();
        int         pick;
        int         n;
        logic [7:0] c;
        string      hexdig;
        string      word;

        hexdig = "0123456789abcdefABCDEF";
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            // noise: any byte value, drives errors from any state
            n = $urandom_range(1, 3);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end else if (pick < 22) begin
            add_byte(";");
            n = $urandom_range(0, 8);
            repeat (n) add_byte(8'($urandom_range(32, 126)));
            add_byte(($urandom_range(0, 5) == 0) ? C_EOB : 8'h0A);
        end else if (pick < 29) begin
            add_byte("%");
            n = $urandom_range(1, 4);
            repeat (n) add_byte(8'($urandom_range("a", "z")));
        end else if (pick < 36) begin
            add_byte("$");
            n = $urandom_range(1, 3);
            repeat (n) add_byte(8'($urandom_range("0", "9")));
        end else if (pick < 44) begin
            // decimal: plain zero, signed or unsigned digits
            if ($urandom_range(0, 3) == 0) begin
                add_byte("0");
            end else begin
                if ($urandom_range(0, 2) == 0)
                    add_byte("-");
                add_byte(8'($urandom_range("1", "9")));
            end
            n = $urandom_range(0, 3);
            repeat (n) add_byte(8'($urandom_range("0", "9")));
        end else if (pick < 50) begin
            add_text("0x");
            n = $urandom_range(1, 4);
            repeat (n) add_byte(hexdig[$urandom_range(0, hexdig.len() - 1)]);
        end else if (pick < 60) begin
            case ($urandom_range(0, 2))
                0:       add_byte(8'($urandom_range("a", "z")));
                1:       add_byte(8'($urandom_range("A", "Z")));
                default: add_byte("_");
            endcase
            n = $urandom_range(0, 5);
            repeat (n) add_byte(rand_word_char());
        end else if (pick < 68) begin
            // string with escapes; escaped byte may be a quote
            add_byte(8'h22);
            n = $urandom_range(0, 6);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_byte(8'h5C);
                    c = 8'($urandom_range(0, 254));
                    if (c == 8'h0A)
                        c = "n";
                    add_byte(c);
                end else begin
                    c = 8'($urandom_range(0, 254));
                    if (c == 8'h0A || c == 8'h22 || c == 8'h5C)
                        c = "a";
                    add_byte(c);
                end
            end
            add_byte(8'h22);
        end else if (pick < 76) begin
            case ($urandom_range(0, 2))
                0:       add_byte(":");
                1:       add_byte("{");
                default: add_byte("}");
            endcase
        end else if (pick < 81) begin
            add_text("_la");
            if ($urandom_range(0, 4) == 0)
                add_byte(rand_word_char());
        end else if (pick < 86) begin
            add_text(($urandom_range(0, 1) == 0) ? ".bss" : ".data");
        end else if (pick < 98) begin
            case ($urandom_range(0, 6))
                0:       word = "AND";
                1:       word = "ADD";
                2:       word = "ORR";
                3:       word = "SHL";
                4:       word = "SHR";
                5:       word = "SUB";
                default: word = "XOR";
            endcase
            // sometimes cut short or run on; a run-on keyword falls back to a label
            case ($urandom_range(0, 4))
                0: add_text(word.substr(0, $urandom_range(0, 1)));
                1: begin
                    add_text(word);
                    add_byte(rand_word_char());
                end
                default: add_text(word);
            endcase
        end else begin
            add_byte(C_EOB);
        end

        case ($urandom_range(0, 7))
            0:       add_byte(" ");
            1:       add_byte(8'h09);
            2:       add_byte(8'h0A);
            3:       add_byte(8'h0D);
            6:       add_byte(":");
            default: ;
        endcase
    endtask

    initial begin
        int idx;
        int burst;
        int gap;

        // Directed opening: extremes and the end-of-input corner cases.
        add_byte(8'h00);                // no transition from start: error
        add_byte(C_EOB);                // eof at start, state stays start
        add_text("%z");
        add_byte(C_EOB);                // flags closed by eof, then eof
        add_byte("$");
        add_byte(C_EOB);                // eof right after '$': error
        add_text("\"a");
        add_byte(C_EOB);                // eof inside a string: error
        add_byte(";");
        add_byte(C_EOB);                // comment then eof
        add_text("0xF:");               // hex immediate closed by colon
        add_byte("-");                  // colon closed, minus opens
        add_byte(8'h80);                // minus needs a digit: error
        add_text("{}");                 // lcurly closed by rcurly
        add_byte(8'h80);                // rcurly then error on the re-run
        add_text(".d");
        add_byte(C_EOB);                // eof inside a directive: error
        add_text("$9");
        add_byte(C_EOB);                // register then eof

        while (words < WORD_TARGET)
            emit_token();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender: bursts of random length, random gaps; about a third of
        // bursts run straight into the next with no gap.
        idx = 0;
        while (idx < src_bytes.size()) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            while (burst > 0 && idx < src_bytes.size()) begin
                @(negedge clk);
                push = 1'b1;
                char_byte = src_bytes[idx];
                @(posedge clk);
                if (!full) begin
                    idx++;
                    burst--;
                end
            end
            repeat (gap) begin
                @(negedge clk);
                push = 1'b0;
                char_byte = 8'($urandom_range(0, 255));   // junk while idle
            end
        end
        @(negedge clk);
        push = 1'b0;

        // Drain, then keep watching to catch stray results.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        // anything still queued in the block is a result nobody predicted
        if (mismatches == 0 && empty === 1'b1)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
